// ===== sv/bb3x3_pkg.sv =====
package bb3x3_pkg;

	// image geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_DIM    = 3;

	// field and register widths
	localparam int PIX_W    = 8;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 12;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int SUM_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// floor(sum / 9) as (sum * 3641) >> 15, exact for sums below 32768
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;
	localparam int PROD_W     = 2 * SUM_W;

	typedef logic [PIX_W-1:0]    pix_t;
	typedef logic [COL_W-1:0]    col_t;
	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [WIDTH_W-1:0]  width_t;
	typedef logic [HEIGHT_W-1:0] height_t;
	typedef logic [SUM_W-1:0]    sum_t;

endpackage

// ===== sv/box_blur_3x3.sv =====
// 3x3 box blur over a raster-order stream of 8-bit samples.
// Input channel: in_valid / in_stall with pixel_value, one word per pixel,
// row 0 first, column 0 first within each row.
// Output channel: out_valid / out_stall with blurred_value, out_column,
// out_row and frame_last. Only interior pixels produce a word; border
// pixels produce none. frame_last marks the last interior pixel.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 is image_width, index 1 is image_height. cfg_ready is always
// high; write only while the block is idle.
// Path: an accepted word waits in stage 1 for its line store reads, its sum
// is registered in stage 2, and its quotient is loaded into the output register.
// Throughput: one pixel per clock unless a stall holds it, set by the two-port
// line stores (one read and one write each cycle).
// Reset: counters restart at row 0, column 0, width 1024, height 4096.
// Line store contents are not cleared and need no clearing pass.
// When out_stall holds a waiting result, the pipeline fills behind it and
// in_stall rises only once every stage is occupied.
module box_blur_3x3 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bb3x3_pkg::pix_t                     pixel_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bb3x3_pkg::pix_t                     blurred_value,
	output bb3x3_pkg::col_t                     out_column,
	output bb3x3_pkg::row_t                     out_row,
	output logic                                frame_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bb3x3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bb3x3_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bb3x3_pkg::width_t  image_width_q, eff_w;
	bb3x3_pkg::height_t image_height_q, eff_h;
	bb3x3_pkg::col_t    column_count_q, col0;
	bb3x3_pkg::row_t    row_count_q, row0;
	logic [bb3x3_pkg::HEIGHT_W-1:0] row_ext;
	logic               col_wrap, col_last, accept;
	logic               emit0, last0;

	logic               v_s1, emit_s1, last_s1;
	bb3x3_pkg::col_t    col_s1;
	bb3x3_pkg::row_t    row_s1;
	bb3x3_pkg::pix_t    bot_s1, top_rd, mid_rd;
	bb3x3_pkg::pix_t    win_q [6];
	bb3x3_pkg::sum_t    sum;

	logic               v_s2, last_s2;
	bb3x3_pkg::sum_t    sum_s2;
	bb3x3_pkg::col_t    col_s2;
	bb3x3_pkg::row_t    row_s2;
	logic [bb3x3_pkg::PROD_W-1:0] prod;

	logic               adv_out, en_s2, en_s1;

	// flow control: each stage moves when the next one is free or moving
	assign adv_out  = !out_valid || !out_stall;
	assign en_s2    = !v_s2 || adv_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bb3x3_pkg::width_t'(bb3x3_pkg::MAX_WIDTH);
			image_height_q <= bb3x3_pkg::height_t'(bb3x3_pkg::MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == bb3x3_pkg::CFG_IMAGE_WIDTH) begin
				image_width_q <= cfg_data[bb3x3_pkg::WIDTH_W-1:0];
			end else if (cfg_index == bb3x3_pkg::CFG_IMAGE_HEIGHT) begin
				image_height_q <= cfg_data;
			end
		end
	end

	// clamp geometry to the supported range
	always_comb begin
		priority if (image_width_q < bb3x3_pkg::width_t'(bb3x3_pkg::MIN_DIM))
			eff_w = bb3x3_pkg::width_t'(bb3x3_pkg::MIN_DIM);
		else if (image_width_q > bb3x3_pkg::width_t'(bb3x3_pkg::MAX_WIDTH))
			eff_w = bb3x3_pkg::width_t'(bb3x3_pkg::MAX_WIDTH);
		else
			eff_w = image_width_q;
		priority if (image_height_q < bb3x3_pkg::height_t'(bb3x3_pkg::MIN_DIM))
			eff_h = bb3x3_pkg::height_t'(bb3x3_pkg::MIN_DIM);
		else if (image_height_q > bb3x3_pkg::height_t'(bb3x3_pkg::MAX_HEIGHT))
			eff_h = bb3x3_pkg::height_t'(bb3x3_pkg::MAX_HEIGHT);
		else
			eff_h = image_height_q;
	end

	// position of the incoming pixel, wrapping if geometry shrank
	always_comb begin
		col_wrap = {1'b0, column_count_q} >= eff_w;
		col0     = col_wrap ? '0 : column_count_q;
		row_ext  = {1'b0, row_count_q} + bb3x3_pkg::HEIGHT_W'(col_wrap);
		row0     = (row_ext >= eff_h) ? '0 : row_ext[bb3x3_pkg::ROW_W-1:0];
		col_last = ({1'b0, col0} + bb3x3_pkg::WIDTH_W'(1)) >= eff_w;
		emit0    = (row0 >= bb3x3_pkg::row_t'(2)) && (col0 >= bb3x3_pkg::col_t'(2));
		last0    = ({1'b0, row0} == eff_h - bb3x3_pkg::height_t'(1))
			&& ({1'b0, col0} == eff_w - bb3x3_pkg::width_t'(1));
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (col_last) begin
				column_count_q <= '0;
				if (({1'b0, row0} + bb3x3_pkg::HEIGHT_W'(1)) >= eff_h)
					row_count_q <= '0;
				else
					row_count_q <= row0 + bb3x3_pkg::row_t'(1);
			end else begin
				column_count_q <= col0 + bb3x3_pkg::col_t'(1);
				row_count_q    <= row0;
			end
		end
	end

	// line stores: middle takes the new pixel, upper takes the old middle
	bb3x3_ram #(
		.WIDTH(bb3x3_pkg::PIX_W),
		.DEPTH(bb3x3_pkg::MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (v_s1 && en_s2),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (en_s1),
		.raddr (col0),
		.rdata (top_rd)
	);

	bb3x3_ram #(
		.WIDTH(bb3x3_pkg::PIX_W),
		.DEPTH(bb3x3_pkg::MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (accept),
		.waddr (col0),
		.wdata (pixel_value),
		.re    (en_s1),
		.raddr (col0),
		.rdata (mid_rd)
	);

	// stage 1: pixel and position wait for the line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col0;
			row_s1  <= row0;
			bot_s1  <= pixel_value;
			emit_s1 <= emit0;
			last_s1 <= last0;
		end
	end

	// nine-sample sum
	always_comb begin
		sum = bb3x3_pkg::sum_t'(top_rd) + bb3x3_pkg::sum_t'(mid_rd)
			+ bb3x3_pkg::sum_t'(bot_s1);
		for (int i = 0; i < 6; i++) begin
			sum = sum + bb3x3_pkg::sum_t'(win_q[i]);
		end
	end

	// window columns shift once per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1 && en_s2) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= bot_s1;
		end
	end

	// stage 2: interior pixels only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1 && emit_s1) begin
			sum_s2  <= sum;
			col_s2  <= col_s1 - bb3x3_pkg::col_t'(1);
			row_s2  <= row_s1 - bb3x3_pkg::row_t'(1);
			last_s2 <= last_s1;
		end
	end

	// divide by nine through a reciprocal multiply
	assign prod = bb3x3_pkg::PROD_W'(sum_s2) * bb3x3_pkg::PROD_W'(bb3x3_pkg::DIV9_MUL);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_out) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			blurred_value <= prod[bb3x3_pkg::DIV9_SHIFT +: bb3x3_pkg::PIX_W];
			out_column    <= col_s2;
			out_row       <= row_s2;
			frame_last    <= last_s2;
		end
	end

endmodule

// ===== sv/bb3x3_ram.sv =====
module bb3x3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/bb3x3_checker.sv =====
module bb3x3_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input bb3x3_pkg::pix_t                  blurred_value,
	input bb3x3_pkg::col_t                  out_column,
	input bb3x3_pkg::row_t                  out_row,
	input logic                             frame_last
);

	// a stalled result word holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blurred_value)
			&& $stable(out_column) && $stable(out_row) && $stable(frame_last))
	else $error("stalled output word changed");

	// a result word only goes away after it was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
	else $error("output word dropped without hand-off");

	// input backpressure only when the output is full and stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("input stalled while output side free");

	// pixels in row 0 or column 0 never produce a result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_column != '0) && (out_row != '0))
	else $error("result emitted for a border pixel");

endmodule

bind box_blur_3x3 bb3x3_checker u_bb3x3_checker (.*);

// ===== verif/tb_box_blur_3x3.sv =====
`timescale 1ns / 1ps

module tb_box_blur_3x3;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [bb3x3_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [bb3x3_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct packed {
		bb3x3_pkg::pix_t value;
		bb3x3_pkg::col_t column;
		bb3x3_pkg::row_t row;
		logic last;
	} blur_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bb3x3_pkg::pix_t pixel_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bb3x3_pkg::pix_t blurred_value;
	bb3x3_pkg::col_t out_column;
	bb3x3_pkg::row_t out_row;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bb3x3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bb3x3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// pixel source and result sink state
	bb3x3_pkg::pix_t pixel_queue [$];
	blur_word_t pending_blur [$];
	logic pix_taken = 1'b0;
	logic out_taken = 1'b0;
	int feed_wait = 0;
	int feed_gap_max = 4;
	int drain_wait = 0;
	int drain_gap_max = 4;
	logic hold_off = 1'b0;
	int error_count = 0;
	int cycle_count = 0;

	// shadow of the blur pipeline
	bb3x3_pkg::pix_t upper_line [bb3x3_pkg::MAX_WIDTH];
	bb3x3_pkg::pix_t middle_line [bb3x3_pkg::MAX_WIDTH];
	bb3x3_pkg::pix_t win_cols [6];
	int unsigned col_cnt = 0;
	int unsigned row_cnt = 0;
	bb3x3_pkg::width_t width_reg = bb3x3_pkg::width_t'(bb3x3_pkg::MAX_WIDTH);
	bb3x3_pkg::height_t height_reg = bb3x3_pkg::height_t'(bb3x3_pkg::MAX_HEIGHT);

	box_blur_3x3 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_value   (pixel_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.blurred_value (blurred_value),
		.out_column    (out_column),
		.out_row       (out_row),
		.frame_last    (frame_last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clamp_dim(input int v, input int hi);
		if (v < bb3x3_pkg::MIN_DIM)
			return bb3x3_pkg::MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int eff_width();
		return clamp_dim(int'(width_reg), bb3x3_pkg::MAX_WIDTH);
	endfunction

	function automatic int eff_height();
		return clamp_dim(int'(height_reg), bb3x3_pkg::MAX_HEIGHT);
	endfunction

	// pixels still needed to bring the raster position back to row 0, column 0
	function automatic int frame_remainder();
		int w;
		int h;
		int c;
		int r;
		w = eff_width();
		h = eff_height();
		c = col_cnt;
		r = row_cnt;
		if (c == 0 && r == 0)
			return 0;
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h)
			r = 0;
		return (h - r) * w - c;
	endfunction

	// one pixel into the window; queues the blurred word of an interior centre
	function automatic void advance_window(input bb3x3_pkg::pix_t bot);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int unsigned idx;
		int unsigned total;
		bb3x3_pkg::pix_t top;
		bb3x3_pkg::pix_t mid;
		blur_word_t res;
		w = eff_width();
		h = eff_height();
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= h)
			row_cnt = 0;
		c = col_cnt;
		r = row_cnt;
		idx = (c < bb3x3_pkg::MAX_WIDTH) ? c : bb3x3_pkg::MAX_WIDTH - 1;
		top = upper_line[idx];
		mid = middle_line[idx];
		if (r >= 2 && c >= 2) begin
			total = int'(top) + int'(mid) + int'(bot);
			foreach (win_cols[i])
				total += win_cols[i];
			res.value = bb3x3_pkg::pix_t'(total / 9);
			res.column = bb3x3_pkg::col_t'(c - 1);
			res.row = bb3x3_pkg::row_t'(r - 1);
			res.last = (r == h - 1) && (c == w - 1);
			pending_blur.push_back(res);
		end
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = top;
		win_cols[4] = mid;
		win_cols[5] = bot;
		upper_line[idx] = mid;
		middle_line[idx] = bot;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else
			col_cnt = c + 1;
	endfunction

	// shadow update, register writes and result checking
	always @(posedge clk) begin
		blur_word_t want;
		if (!arst_n) begin
			col_cnt = 0;
			row_cnt = 0;
			foreach (win_cols[i])
				win_cols[i] = '0;
			width_reg = bb3x3_pkg::width_t'(bb3x3_pkg::MAX_WIDTH);
			height_reg = bb3x3_pkg::height_t'(bb3x3_pkg::MAX_HEIGHT);
			pix_taken <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			pix_taken <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (pending_blur.size() == 0) begin
					$error("unexpected word: column %0d row %0d value %0d",
						out_column, out_row, blurred_value);
					error_count++;
				end else begin
					want = pending_blur.pop_front();
					if (blurred_value !== want.value) begin
						$error("blurred_value: expected %0d, got %0d", want.value, blurred_value);
						error_count++;
					end
					if (out_column !== want.column) begin
						$error("out_column: expected %0d, got %0d", want.column, out_column);
						error_count++;
					end
					if (out_row !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, out_row);
						error_count++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last: expected %0d, got %0d", want.last, frame_last);
						error_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bb3x3_pkg::CFG_IMAGE_WIDTH:
						width_reg = cfg_data[bb3x3_pkg::WIDTH_W-1:0];
					bb3x3_pkg::CFG_IMAGE_HEIGHT:
						height_reg = cfg_data[bb3x3_pkg::HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				advance_window(pixel_value);
		end
	end

	// pixel source: random gap before each word, payload held while stalled
	always @(negedge clk) begin
		if (arst_n && (!in_valid || pix_taken)) begin
			if (feed_wait > 0) begin
				feed_wait <= feed_wait - 1;
				in_valid <= 1'b0;
			end else if (pixel_queue.size() > 0) begin
				in_valid <= 1'b1;
				pixel_value <= pixel_queue.pop_front();
				feed_wait <= $urandom_range(0, feed_gap_max);
			end else
				in_valid <= 1'b0;
		end
	end

	// result sink: random stall per word, plus the long hold-off
	always @(negedge clk) begin
		int w;
		w = out_taken ? int'($urandom_range(0, drain_gap_max)) : drain_wait;
		if (hold_off)
			out_stall <= 1'b1;
		else begin
			out_stall <= (w > 0);
			if (out_valid && w > 0)
				w--;
		end
		drain_wait <= w;
	end

	// watchdog
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("box_blur_3x3 verification failed");
		$finish;
	end

	task automatic queue_pixels(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			case ($urandom_range(0, 7))
				0: pixel_queue.push_back(8'h00);
				1: pixel_queue.push_back(8'hFF);
				default: pixel_queue.push_back(bb3x3_pkg::pix_t'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// wait for the source to drain, every word to arrive, and the pipe to empty
	task automatic settle();
		while (pixel_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_blur.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bb3x3_pkg::CFG_IDX_W-1:0] idx,
			input logic [bb3x3_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// a wider line is only taken at the start of a frame so no stale column is read
	task automatic reconfigure(input int raw_w, input int raw_h);
		int left;
		if (clamp_dim(raw_w & 'h7FF, bb3x3_pkg::MAX_WIDTH) > eff_width()) begin
			left = frame_remainder();
			if (left > 0) begin
				queue_pixels(left);
				settle();
			end
		end
		if ($urandom_range(0, 1)) begin
			write_reg(bb3x3_pkg::CFG_IMAGE_WIDTH, bb3x3_pkg::CFG_DATA_W'(raw_w));
			write_reg(bb3x3_pkg::CFG_IMAGE_HEIGHT, bb3x3_pkg::CFG_DATA_W'(raw_h));
		end else begin
			write_reg(bb3x3_pkg::CFG_IMAGE_HEIGHT, bb3x3_pkg::CFG_DATA_W'(raw_h));
			write_reg(bb3x3_pkg::CFG_IMAGE_WIDTH, bb3x3_pkg::CFG_DATA_W'(raw_w));
		end
	endtask

	// stimulus
	initial begin
		int k;
		int fed;
		int round;
		int raw_w;
		int raw_h;
		int n;
		int area;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// start of row 0 at the reset geometry
		for (k = 0; k < 5; k++)
			pixel_queue.push_back(8'hFF);
		pixel_queue.push_back(8'h5A);
		settle();

		// width lowered under the current column: line ends, next rows give max and mid sums
		write_reg(bb3x3_pkg::CFG_IMAGE_WIDTH, 13'd5);
		for (k = 0; k < 10; k++)
			pixel_queue.push_back(8'hFF);
		for (k = 0; k < 5; k++)
			pixel_queue.push_back(8'h00);
		settle();

		// height lowered under the current row restarts the frame; width below minimum
		write_reg(bb3x3_pkg::CFG_IMAGE_HEIGHT, 13'd3);
		write_reg(bb3x3_pkg::CFG_IMAGE_WIDTH, 13'd0);
		for (k = 0; k < 9; k++)
			pixel_queue.push_back(8'h00);
		settle();

		// unmapped indexes must be ignored
		write_reg(CFG_SPARE_2, 13'h0AAA);
		write_reg(CFG_SPARE_3, 13'h1555);

		// widest line: the first row runs on with no wrap and no result
		reconfigure(13'h1FFF, 0);
		queue_pixels(100);
		settle();

		// tall frame at the narrowest line, then back to a short frame
		feed_gap_max = 0;
		drain_gap_max = 0;
		reconfigure(1, 13'h1FFF);
		queue_pixels(bb3x3_pkg::MIN_DIM * 40);
		settle();
		write_reg(bb3x3_pkg::CFG_IMAGE_HEIGHT, bb3x3_pkg::CFG_DATA_W'(bb3x3_pkg::MIN_DIM));

		// random geometries, mostly whole frames, some cut short
		fed = 0;
		round = 0;
		while (fed < 350 || round < 3) begin
			feed_gap_max = $urandom_range(0, 1) ? 4 : 0;
			drain_gap_max = $urandom_range(0, 1) ? 4 : 0;
			if (round == 2) begin
				// sink holds off while the source keeps pushing
				feed_gap_max = 0;
				reconfigure(8, 20);
				queue_pixels(160);
				fed += 160;
				@(posedge clk);
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				if ($urandom_range(0, 9) == 0)
					raw_w = $urandom_range(0, 2);
				else if ($urandom_range(0, 3) == 0)
					raw_w = $urandom_range(13, 40);
				else
					raw_w = $urandom_range(3, 12);
				raw_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
					: $urandom_range(3, 8);
				reconfigure(raw_w, raw_h);
				area = clamp_dim(raw_w, bb3x3_pkg::MAX_WIDTH)
					* clamp_dim(raw_h, bb3x3_pkg::MAX_HEIGHT);
				n = $urandom_range(1, 2) * area;
				if ($urandom_range(0, 2) == 0)
					n += $urandom_range(1, area - 1);
				queue_pixels(n);
				fed += n;
			end
			settle();
			round++;
		end

		if (error_count == 0)
			$display("box_blur_3x3 verification clean");
		else
			$display("box_blur_3x3 verification failed");
		$finish;
	end

endmodule
